/* rtl/pd3_pkg.sv */
package pd3_pkg;

	// Width of every coordinate field and of the box register
	localparam int FIELD_BITS = 24;
	// Default number of low coordinate bits taken into account
	localparam int COORD_BITS = 24;
	// Width of the distance result
	localparam int DIST_BITS = 25;
	// Entries in the queue between front and back
	localparam int QUEUE_DEPTH = 8;
	// Box size after reset
	localparam logic [FIELD_BITS-1:0] BOX_RESET = {FIELD_BITS{1'b1}};

	typedef logic [FIELD_BITS-1:0] coord_t;

	typedef struct packed {
		coord_t first_x;
		coord_t first_y;
		coord_t first_z;
		coord_t second_x;
		coord_t second_y;
		coord_t second_z;
	} in_item_t;

	typedef struct packed {
		logic [DIST_BITS-1:0] distance;
		logic                 beyond_half_diagonal;
	} result_t;

endpackage

/* rtl/periodic_distance_3d.sv */
// Minimum-image distance between two points in a periodic cubic box.
//
// Input channel: drive item with push; the item is taken on a clock edge where
// push is high and full is low. Result channel: while empty is low, result holds
// the oldest finished distance and flag; raise pop to transfer it.
// Configuration: cfg_data is written into the box size on an edge where
// cfg_valid is high; cfg_ready is always high. Write it only while no item is
// in flight.
//
// Throughput: one item per cycle while the receiver keeps popping. The front
// folds, squares and sums in five stages and feeds an eight-entry queue; the
// back runs a square root that settles one root bit per stage (25 stages) into
// a single output register. When the receiver stalls, the back holds and the
// queue absorbs the front; full rises once eight items are queued or in the
// front stages.
// Reset clears all valid state and sets the box size to its maximum; no result
// is pending afterwards.
module periodic_distance_3d #(
	parameter int COORD_BITS = pd3_pkg::COORD_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  pd3_pkg::in_item_t              item,
	input  logic                           pop,
	output logic                           empty,
	output pd3_pkg::result_t               result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pd3_pkg::FIELD_BITS-1:0] cfg_data
);

	localparam int EB = (COORD_BITS < pd3_pkg::FIELD_BITS) ? COORD_BITS : pd3_pkg::FIELD_BITS;
	localparam int MW = 2 * (EB + 1) + 1;

	logic [pd3_pkg::FIELD_BITS-1:0] box_q;
	logic                           mid_push;
	logic                           mid_pop;
	logic                           mid_empty;
	logic [MW-1:0]                  mid_wdata;
	logic [MW-1:0]                  mid_rdata;

	assign cfg_ready = 1'b1;

	// Hold the box size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q <= pd3_pkg::BOX_RESET;
		end else if (cfg_valid && cfg_ready) begin
			box_q <= cfg_data;
		end
	end

	pd3_front #(
		.COORD_BITS  (COORD_BITS),
		.QUEUE_DEPTH (pd3_pkg::QUEUE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.box      (box_q),
		.mid_push (mid_push),
		.mid_data (mid_wdata),
		.mid_pop  (mid_pop)
	);

	pd3_queue #(
		.WIDTH (MW),
		.DEPTH (pd3_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (mid_push),
		.wr_data (mid_wdata),
		.pop     (mid_pop),
		.rd_data (mid_rdata),
		.empty   (mid_empty)
	);

	pd3_back #(
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_empty (mid_empty),
		.mid_data  (mid_rdata),
		.mid_pop   (mid_pop),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule

/* rtl/pd3_front.sv */
module pd3_front #(
	parameter int COORD_BITS  = pd3_pkg::COORD_BITS,
	parameter int QUEUE_DEPTH = pd3_pkg::QUEUE_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  pd3_pkg::in_item_t                 item,
	input  logic [pd3_pkg::FIELD_BITS-1:0]    box,
	output logic                              mid_push,
	output logic [2*((COORD_BITS < pd3_pkg::FIELD_BITS) ? COORD_BITS : pd3_pkg::FIELD_BITS)+2:0]
	                                          mid_data,
	input  logic                              mid_pop
);

	localparam int EB = (COORD_BITS < pd3_pkg::FIELD_BITS) ? COORD_BITS : pd3_pkg::FIELD_BITS;
	localparam int SW = 2 * EB + 2;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	function automatic logic [EB+1:0] mag(input logic signed [EB+1:0] v);
		return v[EB+1] ? -v : v;
	endfunction

	// First fold step: difference, then try subtracting the box
	function automatic logic signed [EB+1:0] fold_sub(input logic [EB-1:0] a,
			input logic [EB-1:0] b, input logic [EB-1:0] s);
		logic signed [EB+1:0] d;
		logic signed [EB+1:0] e;
		d = $signed({2'b00, a}) - $signed({2'b00, b});
		e = d - $signed({2'b00, s});
		return (mag(e) < mag(d)) ? e : d;
	endfunction

	// Second fold step: try adding the box, return the magnitude
	function automatic logic [EB-1:0] fold_add(input logic signed [EB+1:0] d,
			input logic [EB-1:0] s);
		logic signed [EB+1:0] f;
		logic [EB+1:0]        m;
		f = d + $signed({2'b00, s});
		m = (mag(f) < mag(d)) ? mag(f) : mag(d);
		return m[EB-1:0];
	endfunction

	logic                    accept;
	logic [CW-1:0]           credit_q;
	logic [EB-1:0]           side;
	logic [2*EB-1:0]         side_w;
	logic [2*EB-1:0]         side_sq_q;
	logic [SW-1:0]           thr_q;
	logic [EB-1:0]           pa [3];
	logic [EB-1:0]           pb [3];

	logic                    vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic signed [EB+1:0]    d_s1 [3];
	logic [EB-1:0]           mag_s2 [3];
	logic [2*EB-1:0]         sq_s3 [3];
	logic [SW-1:0]           sum_s4;
	logic [SW-1:0]           sum_s5;
	logic                    flag_s5;

	assign accept = push && !full;
	assign full   = (credit_q == '0);
	assign side   = box[EB-1:0];
	assign side_w = {{EB{1'b0}}, side};

	assign pa[0] = item.first_x[EB-1:0];
	assign pa[1] = item.first_y[EB-1:0];
	assign pa[2] = item.first_z[EB-1:0];
	assign pb[0] = item.second_x[EB-1:0];
	assign pb[1] = item.second_y[EB-1:0];
	assign pb[2] = item.second_z[EB-1:0];

	// Track free queue slots, counting items still in the front pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= CW'(QUEUE_DEPTH);
		end else if (accept && !mid_pop) begin
			credit_q <= credit_q - 1'b1;
		end else if (!accept && mid_pop) begin
			credit_q <= credit_q + 1'b1;
		end
	end

	// Advance the stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// Precompute three times the squared box size
	always_ff @(posedge clk) begin
		side_sq_q <= side_w * side_w;
		thr_q     <= {1'b0, side_sq_q, 1'b0} + {2'b00, side_sq_q};
	end

	// Fold, square and sum the three axes, and compare the sum with the threshold
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			d_s1[i]   <= fold_sub(pa[i], pb[i], side);
			mag_s2[i] <= fold_add(d_s1[i], side);
			sq_s3[i]  <= {{EB{1'b0}}, mag_s2[i]} * {{EB{1'b0}}, mag_s2[i]};
		end
		sum_s4  <= {2'b00, sq_s3[0]} + {2'b00, sq_s3[1]} + {2'b00, sq_s3[2]};
		sum_s5  <= sum_s4;
		flag_s5 <= ({sum_s4, 2'b00} > {2'b00, thr_q});
	end

	assign mid_push = vld_s5;
	assign mid_data = {flag_s5, sum_s5};

`ifndef SYNTHESIS
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		credit_q <= CW'(QUEUE_DEPTH))
		else $error("front credit count above queue depth");
`endif

endmodule

/* rtl/pd3_queue.sv */
module pd3_queue #(
	parameter int WIDTH = 51,
	parameter int DEPTH = pd3_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	// Store the pushed entry
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != CW'(DEPTH)))
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue read while empty");
`endif

endmodule

/* rtl/pd3_back.sv */
module pd3_back #(
	parameter int COORD_BITS = pd3_pkg::COORD_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              mid_empty,
	input  logic [2*((COORD_BITS < pd3_pkg::FIELD_BITS) ? COORD_BITS : pd3_pkg::FIELD_BITS)+2:0]
	                          mid_data,
	output logic              mid_pop,
	input  logic              pop,
	output logic              empty,
	output pd3_pkg::result_t  result
);

	localparam int EB = (COORD_BITS < pd3_pkg::FIELD_BITS) ? COORD_BITS : pd3_pkg::FIELD_BITS;
	// Root bits: one per pipeline stage
	localparam int R  = EB + 1;

	logic             en;
	logic [R:0]       vld_s;
	logic [R:0]       rem_s  [R+1];
	logic [R-1:0]     root_s [R+1];
	logic [2*R-1:0]   rad_s  [R+1];
	logic             flag_s [R+1];
	logic             out_vld_q;
	pd3_pkg::result_t out_q;

	// Move the whole pipeline unless the output register is full and held
	assign en      = !out_vld_q || pop;
	assign mid_pop = en && !mid_empty;
	assign empty   = !out_vld_q;
	assign result  = out_q;

	// Advance stage valid bits and the output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s     <= '0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_s     <= {vld_s[R-1:0], !mid_empty};
			out_vld_q <= vld_s[R];
		end
	end

	// Load the radicand from the queue
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= '0;
			root_s[0] <= '0;
			rad_s[0]  <= mid_data[2*R-1:0];
			flag_s[0] <= mid_data[2*R];
		end
	end

	// One root bit per stage: restoring digit-by-digit square root
	for (genvar i = 1; i <= R; i++) begin : g_root
		logic [R+2:0] cur;
		logic [R+2:0] trial;
		logic [R+2:0] sub;
		logic         ge;

		assign cur   = {rem_s[i-1], rad_s[i-1][2*R-1 -: 2]};
		assign sub   = {1'b0, root_s[i-1], 2'b01};
		assign ge    = (cur >= sub);
		assign trial = cur - sub;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= ge ? trial[R:0] : cur[R:0];
				root_s[i] <= {root_s[i-1][R-2:0], ge};
				rad_s[i]  <= {rad_s[i-1][2*R-3:0], 2'b00};
				flag_s[i] <= flag_s[i-1];
			end
		end
	end

	// Hold the finished result until it is taken
	always_ff @(posedge clk) begin
		if (en) begin
			out_q.distance             <= pd3_pkg::DIST_BITS'(root_s[R]);
			out_q.beyond_half_diagonal <= flag_s[R];
		end
	end

`ifndef SYNTHESIS
	a_root_floor: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[R] |-> (rem_s[R] <= {root_s[R], 1'b0}))
		else $error("square root remainder exceeds twice the root");
`endif

endmodule

/* dv/tb_periodic_distance_3d.sv */
`timescale 1ns / 1ps

module tb_periodic_distance_3d;
	import pd3_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int TAIL_CYCLES = 40;
	localparam int PRINT_CAP = 200;
	localparam int ITEMS_PER_BOX = 175;
	localparam int HOLD_CYCLES = 300;
	localparam longint unsigned COORD_MASK = (64'd1 << COORD_BITS) - 1;
	localparam longint unsigned DIST_MAX = (64'd1 << DIST_BITS) - 1;
	localparam logic [FIELD_BITS-1:0] COORD_MAX = {FIELD_BITS{1'b1}};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic cfg_valid = 1'b0;
	logic [FIELD_BITS-1:0] cfg_data = '0;
	in_item_t item = '0;
	logic full;
	logic empty;
	logic cfg_ready;
	result_t result;

	// Expected results in transfer order, and the box the predictor works with
	result_t pending_distances[$];
	logic [FIELD_BITS-1:0] model_box = BOX_RESET;
	int mismatch_count = 0;
	int cycle_count = 0;
	int burst_left = 0;
	int pop_mode = 0;
	bit gapless = 1'b0;
	logic hold_off = 1'b0;

	always #5 clk = ~clk;

	periodic_distance_3d uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.pop(pop),
		.empty(empty),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	function automatic longint unsigned magnitude_of(input longint v);
		return (v < 0) ? longint'(-v) : longint'(v);
	endfunction

	// Fold one axis difference into the box; return its magnitude
	function automatic longint unsigned fold_axis(input coord_t p, input coord_t q,
			input longint unsigned side);
		longint d;
		longint s;
		d = longint'(p & COORD_MASK) - longint'(q & COORD_MASK);
		s = longint'(side);
		if (magnitude_of(d - s) < magnitude_of(d))
			d = d - s;
		if (magnitude_of(d + s) < magnitude_of(d))
			d = d + s;
		return magnitude_of(d);
	endfunction

	function automatic result_t min_image_distance(input in_item_t it,
			input logic [FIELD_BITS-1:0] box);
		longint unsigned side;
		longint unsigned dx;
		longint unsigned dy;
		longint unsigned dz;
		longint unsigned sum;
		longint unsigned three_sq;
		logic [71:0] root;
		logic [71:0] trial;
		result_t r;
		side = box & COORD_MASK;
		dx = fold_axis(it.first_x, it.second_x, side);
		dy = fold_axis(it.first_y, it.second_y, side);
		dz = fold_axis(it.first_z, it.second_z, side);
		sum = dx * dx + dy * dy + dz * dz;
		three_sq = 3 * side * side;
		// Settle the floor root one bit at a time
		root = '0;
		for (int b = 34; b >= 0; b--) begin
			trial = root | (72'd1 << b);
			if (trial * trial <= {8'd0, sum})
				root = trial;
		end
		if (root > DIST_MAX)
			root = DIST_MAX;
		r.distance = root[DIST_BITS-1:0];
		r.beyond_half_diagonal = (4 * sum > three_sq);
		return r;
	endfunction

	function automatic in_item_t make_item(input coord_t fx, input coord_t fy,
			input coord_t fz, input coord_t sx, input coord_t sy, input coord_t sz);
		in_item_t it;
		it.first_x = fx;
		it.first_y = fy;
		it.first_z = fz;
		it.second_x = sx;
		it.second_y = sy;
		it.second_z = sz;
		return it;
	endfunction

	// Pick one axis pair: wide random, inside the box, near a half-box tie,
	// at the coordinate extremes, or about one box apart
	function automatic void random_axis(input longint unsigned side,
			output coord_t p, output coord_t q);
		int unsigned kind;
		int unsigned lim;
		kind = $urandom_range(0, 9);
		lim = (side == 0) ? COORD_MAX : int'(side - 1);
		if (kind <= 3) begin
			p = $urandom;
			q = $urandom;
		end else if (kind <= 6) begin
			p = $urandom_range(0, lim);
			q = $urandom_range(0, lim);
		end else if (kind == 7) begin
			p = $urandom;
			q = p + coord_t'(side >> 1) + coord_t'($urandom_range(0, 2)) - 1;
		end else if (kind == 8) begin
			p = ($urandom_range(0, 1) != 0) ? COORD_MAX : '0;
			q = ($urandom_range(0, 1) != 0) ? COORD_MAX : '0;
		end else begin
			p = $urandom;
			q = p + coord_t'(side) + coord_t'($urandom_range(0, 4)) - 2;
		end
		if ($urandom_range(0, 1) != 0) begin
			lim = p;
			p = q;
			q = lim;
		end
	endfunction

	function automatic in_item_t random_item(input logic [FIELD_BITS-1:0] box);
		in_item_t it;
		random_axis(box, it.first_x, it.second_x);
		random_axis(box, it.first_y, it.second_y);
		random_axis(box, it.first_z, it.second_z);
		return it;
	endfunction

	task automatic report(input string msg);
		if (mismatch_count < PRINT_CAP)
			$display("MISMATCH at cycle %0d: %s", cycle_count, msg);
		mismatch_count++;
	endtask

	// Offer one item, hold it until the transfer, then maybe pause the burst
	task automatic send_item(input in_item_t it);
		int gap;
		push <= 1'b1;
		item <= it;
		do @(posedge clk); while (full);
		pending_distances.push_back(min_image_distance(it, model_box));
		if (!gapless) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				burst_left = $urandom_range(0, 24);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				if (gap > 0)
					push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Stop offering and wait until every expected result has come back
	task automatic drain();
		push <= 1'b0;
		while (pending_distances.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_box(input logic [FIELD_BITS-1:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		model_box = value;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_reset_box();
		send_item(make_item('0, '0, '0, '0, '0, '0));
		send_item(make_item(COORD_MAX, COORD_MAX, COORD_MAX, '0, '0, '0));
		send_item(make_item('0, '0, '0, COORD_MAX, COORD_MAX, COORD_MAX));
		send_item(make_item(24'h800000, 24'h7FFFFF, 24'hAAAAAA, '0, 24'h555555, 24'hFFFFFE));
	endtask

	task automatic test_box_extremes();
		// Zero box: raw differences, flag on any difference
		set_box('0);
		send_item(make_item(24'h123456, 24'h123456, 24'h123456,
			24'h123456, 24'h123456, 24'h123456));
		send_item(make_item(COORD_MAX, COORD_MAX, COORD_MAX, '0, '0, '0));
		send_item(make_item('0, 24'd1, '0, '0, '0, '0));
		// Unit box: points far outside, each fold applied once
		set_box(24'd1);
		send_item(make_item(24'd5, '0, COORD_MAX, '0, 24'd5, '0));
		send_item(make_item(24'd1, 24'd1, 24'd1, '0, '0, '0));
		send_item(make_item(COORD_MAX, '0, 24'h400000, '0, COORD_MAX, 24'h3FFFFF));
		// Flag boundary: four times the sum equals three box squares
		set_box(24'd2);
		send_item(make_item(24'd1, 24'd1, 24'd1, '0, '0, '0));
		send_item(make_item(24'd2, '0, 24'd1, '0, 24'd1, 24'd3));
		// Half-box ties stay, just past half folds
		set_box(24'd10);
		send_item(make_item(24'd5, '0, 24'd6, '0, 24'd5, '0));
		send_item(make_item(24'd15, 24'd25, '0, '0, '0, 24'd16));
		send_item(make_item(24'd100, 24'd4, 24'd9, 24'd95, 24'd14, '0));
		send_item(make_item('0, '0, '0, 24'd5, 24'd5, 24'd5));
		send_item(make_item(24'd9, 24'd9, 24'd9, '0, '0, '0));
		// Largest box back again
		set_box(COORD_MAX);
		send_item(make_item(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, '0, '0, '0));
		send_item(make_item(24'h800000, 24'h800000, 24'h800000, '0, '0, '0));
	endtask

	task automatic test_random_boxes();
		logic [FIELD_BITS-1:0] boxes[7];
		boxes[0] = COORD_MAX;
		boxes[1] = 24'd1;
		boxes[2] = '0;
		boxes[3] = 24'h800000;
		boxes[4] = $urandom_range(2, 1000);
		boxes[5] = $urandom;
		boxes[6] = $urandom_range(1, COORD_MAX);
		foreach (boxes[i]) begin
			set_box(boxes[i]);
			repeat (ITEMS_PER_BOX) send_item(random_item(model_box));
		end
	endtask

	// Hold the receiver off while items keep coming, so the block fills
	task automatic test_receiver_holdoff();
		drain();
		gapless = 1'b1;
		fork
			begin
				hold_off <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off <= 1'b0;
			end
		join_none
		repeat (40) send_item(random_item(model_box));
		gapless = 1'b0;
		drain();
	endtask

	// Check each result transfer; choose the next pop from the stall pattern
	always @(posedge clk) begin : check_results
		result_t want;
		if (pop && !empty) begin
			if (pending_distances.size() == 0) begin
				report($sformatf("result with none expected, distance %0d", result.distance));
			end else begin
				want = pending_distances.pop_front();
				if (result.distance !== want.distance)
					report($sformatf("distance got %0d expected %0d",
						result.distance, want.distance));
				if (result.beyond_half_diagonal !== want.beyond_half_diagonal)
					report($sformatf("beyond_half_diagonal got %0b expected %0b",
						result.beyond_half_diagonal, want.beyond_half_diagonal));
			end
		end
		if (cycle_count % 64 == 0)
			pop_mode <= $urandom_range(0, 3);
		if (hold_off)
			pop <= 1'b0;
		else case (pop_mode)
			0: pop <= 1'b1;
			1: pop <= ($urandom_range(0, 1) != 0);
			2: pop <= ($urandom_range(0, 7) == 0);
			default: pop <= (cycle_count % 5 != 0);
		endcase
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_box();
		test_box_extremes();
		test_random_boxes();
		test_receiver_holdoff();
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
